// ===== rtl/gpd_pkg.sv =====
// Shared types and constants of the grid peak detector.
`timescale 1ns / 1ps

package gpd_pkg;

	// Configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

	// Input item codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// Result field widths
	localparam int OUT_ROW_W = 10;
	localparam int OUT_COL_W = 10;

	// Queue depths, powers of two
	localparam int JOB_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	// Classification of one center, handed from the front to the back.
	typedef struct packed {
		logic                 is_sample;
		logic                 check;
		logic                 up_ok;
		logic                 down_ok;
		logic                 left_ok;
		logic                 right_ok;
		logic                 last;
		logic [OUT_ROW_W-1:0] row;
	} job_t;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 done;
	} res_t;

endpackage

// ===== rtl/gpd_fifo.sv =====
// Small register-based FIFO used for the job queue and the result queue.
`timescale 1ns / 1ps

module gpd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ===== rtl/gpd_front.sv =====
// Front end: size registers, raster counters and classification of each item.
`timescale 1ns / 1ps

module gpd_front #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024,
	parameter int COL_AW   = 10,
	parameter int ROW_W    = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [gpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        push,
	input  logic                        op,
	input  logic                        job_full,
	output logic                        job_push,
	output gpd_pkg::job_t               job_flags,
	output logic [COL_AW-1:0]           job_col
);

	logic [gpd_pkg::CFG_W-1:0] grid_rows_q;
	logic [gpd_pkg::CFG_W-1:0] grid_cols_q;
	logic [ROW_W-1:0]          row_q;
	logic [COL_AW-1:0]         col_q;
	logic [COL_AW-1:0]         flush_q;

	logic [31:0]       rows_w;
	logic [31:0]       cols_w;
	logic [31:0]       row_m1_w;
	logic [ROW_W-1:0]  rows;
	logic [COL_AW:0]   cols;
	logic [COL_AW:0]   col_nxt;
	logic [COL_AW:0]   flush_nxt;
	logic [ROW_W-1:0]  row_m1;
	logic              complete;
	logic              accept;
	logic              is_sample;

	// Out-of-range sizes act as the nearest legal size.
	always_comb begin
		if (grid_rows_q == '0) begin
			rows_w = 32'd1;
		end else if ({{(32-gpd_pkg::CFG_W){1'b0}}, grid_rows_q} > 32'(MAX_ROWS)) begin
			rows_w = 32'(MAX_ROWS);
		end else begin
			rows_w = {{(32-gpd_pkg::CFG_W){1'b0}}, grid_rows_q};
		end
		if (grid_cols_q == '0) begin
			cols_w = 32'd1;
		end else if ({{(32-gpd_pkg::CFG_W){1'b0}}, grid_cols_q} > 32'(MAX_COLS)) begin
			cols_w = 32'(MAX_COLS);
		end else begin
			cols_w = {{(32-gpd_pkg::CFG_W){1'b0}}, grid_cols_q};
		end
	end

	assign rows      = rows_w[ROW_W-1:0];
	assign cols      = cols_w[COL_AW:0];
	assign complete  = (row_q >= rows);
	assign col_nxt   = {1'b0, col_q} + 1'b1;
	assign flush_nxt = {1'b0, flush_q} + 1'b1;
	assign row_m1    = row_q - 1'b1;
	assign row_m1_w  = {{(32-ROW_W){1'b0}}, row_m1};
	assign is_sample = (op == gpd_pkg::OP_SAMPLE);
	assign accept    = push && !job_full;

	// A sample counts only while the frame is open, a flush only after it is complete.
	assign job_push = accept && (is_sample ? !complete : complete);

	always_comb begin
		job_flags.is_sample = is_sample;
		job_flags.check     = is_sample ? (row_q != '0) : 1'b1;
		job_flags.up_ok     = (row_q >= ROW_W'(2));
		job_flags.down_ok   = is_sample;
		job_flags.left_ok   = is_sample ? (col_q != '0) : (flush_q != '0);
		job_flags.last      = !is_sample && (flush_nxt >= cols);
		job_flags.right_ok  = is_sample ? (col_nxt < cols) : (flush_nxt < cols);
		job_flags.row       = row_m1_w[gpd_pkg::OUT_ROW_W-1:0];
		job_col             = is_sample ? col_q : flush_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= gpd_pkg::CFG_W'(1);
			grid_cols_q <= gpd_pkg::CFG_W'(1);
			row_q       <= '0;
			col_q       <= '0;
			flush_q     <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					gpd_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data;
					gpd_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (job_push) begin
				if (is_sample) begin
					if (col_nxt >= cols) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_nxt[COL_AW-1:0];
					end
				end else if (flush_nxt >= cols) begin
					flush_q <= '0;
					row_q   <= '0;
					col_q   <= '0;
				end else begin
					flush_q <= flush_nxt[COL_AW-1:0];
				end
			end
		end
	end

endmodule

// ===== rtl/gpd_back.sv =====
// Back end: line buffers, neighbor window and the peak decision.
`timescale 1ns / 1ps

module gpd_back #(
	parameter int MAX_COLS    = 1024,
	parameter int COL_AW      = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  job_empty,
	input  gpd_pkg::job_t                         job_flags,
	input  logic [COL_AW-1:0]                     job_col,
	input  logic [SAMPLE_BITS-1:0]                job_sample,
	output logic                                  job_pop,
	input  logic [$clog2(gpd_pkg::RES_DEPTH+1)-1:0] res_level,
	output logic                                  res_push,
	output gpd_pkg::res_t                         res_data
);

	localparam int LVL_W = $clog2(gpd_pkg::RES_DEPTH+1);

	logic [SAMPLE_BITS-1:0] line_one_mem [MAX_COLS];
	logic [SAMPLE_BITS-1:0] line_two_mem [MAX_COLS];

	logic                   v_s1;
	gpd_pkg::job_t          flags_s1;
	logic [COL_AW-1:0]      col_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] cen_rd_s1;
	logic [SAMPLE_BITS-1:0] right_rd_s1;
	logic [SAMPLE_BITS-1:0] up_rd_s1;
	logic                   fwd_s1;
	logic [SAMPLE_BITS-1:0] fwd_val_s1;
	logic [SAMPLE_BITS-1:0] cen_q;

	logic [COL_AW-1:0]      right_addr;
	logic [COL_AW:0]        col_inc;
	logic [SAMPLE_BITS-1:0] up_val;
	logic [LVL_W:0]         slots_used;
	logic [31:0]            col_w;
	logic                   peak;

	assign col_inc    = {1'b0, job_col} + 1'b1;
	assign right_addr = (col_inc < (COL_AW+1)'(MAX_COLS)) ? col_inc[COL_AW-1:0] : job_col;

	// Reserve a result slot for the center in flight so a decision never stalls.
	assign slots_used = {1'b0, res_level} + {{LVL_W{1'b0}}, v_s1};
	assign job_pop    = !job_empty && (slots_used < (LVL_W+1)'(gpd_pkg::RES_DEPTH));

	// The line two write of the center in flight lands at the same edge as this read.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cen_rd_s1   <= line_one_mem[job_col];
			right_rd_s1 <= line_one_mem[right_addr];
			up_rd_s1    <= line_two_mem[job_col];
			if (job_flags.is_sample) begin
				line_one_mem[job_col] <= job_sample;
			end
			flags_s1   <= job_flags;
			col_s1     <= job_col;
			sample_s1  <= job_sample;
			fwd_s1     <= v_s1 && flags_s1.is_sample && (col_s1 == job_col);
			fwd_val_s1 <= cen_rd_s1;
		end
		if (v_s1 && flags_s1.is_sample) begin
			line_two_mem[col_s1] <= cen_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			cen_q <= '0;
		end else begin
			v_s1 <= job_pop;
			if (v_s1) begin
				cen_q <= cen_rd_s1;
			end
		end
	end

	assign up_val = fwd_s1 ? fwd_val_s1 : up_rd_s1;

	// The left neighbor is the center decided just before this one.
	assign peak = flags_s1.check
		&& !(flags_s1.up_ok    && (cen_rd_s1 < up_val))
		&& !(flags_s1.down_ok  && (cen_rd_s1 < sample_s1))
		&& !(flags_s1.left_ok  && (cen_rd_s1 < cen_q))
		&& !(flags_s1.right_ok && (cen_rd_s1 < right_rd_s1));

	assign col_w    = {{(32-COL_AW){1'b0}}, col_s1};
	assign res_push = v_s1 && peak;

	always_comb begin
		res_data.row  = flags_s1.row;
		res_data.col  = col_w[gpd_pkg::OUT_COL_W-1:0];
		res_data.done = flags_s1.last;
	end

`ifndef SYNTHESIS
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_level < LVL_W'(gpd_pkg::RES_DEPTH)))
		else $error("result transfer into a full result queue");

	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && fwd_s1) |-> $past(v_s1 && flags_s1.is_sample))
		else $error("line buffer bypass without a sample writing it");

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && flags_s1.last) |-> !flags_s1.is_sample)
		else $error("frame end marked on a sample center");

	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (res_level < LVL_W'(gpd_pkg::RES_DEPTH)))
		else $error("center taken with no result slot left");
`endif

endmodule

// ===== rtl/grid_peak_detector_4n.sv =====
// Top level of the streaming 4-neighbor grid peak detector.
`timescale 1ns / 1ps

// Samples of a grid_rows x grid_cols grid are pushed in raster order, one per
// clock at most, followed by grid_cols flush items that decide the last row;
// the counters then restart for the next frame. Each cell whose value is at
// least as large as its in-grid up, down, left and right neighbors is reported
// as a row/column pair in raster order, and the report for the last cell of
// the frame carries frame_done. A center is decided when the sample below it
// arrives. While the result queue has room, the block sustains one item per
// clock: the front end classifies an item in the cycle it is accepted, and the
// back end reads both line buffers and decides one center per cycle, limited by
// the single write port of each line buffer. Centers are registered in the back
// end read stage. Four-entry job and result queues decouple the two halves;
// push stalls only on a full job queue. The line buffers need no clearing after
// reset. Grid sizes must be written only between frames; this is not enforced.

module grid_peak_detector_4n #(
	parameter int MAX_COLS    = 1024,
	parameter int MAX_ROWS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [gpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gpd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic                            op,
	input  logic [SAMPLE_BITS-1:0]          sample_value,
	output logic                            empty,
	input  logic                            pop,
	output logic [gpd_pkg::OUT_ROW_W-1:0]   peak_row,
	output logic [gpd_pkg::OUT_COL_W-1:0]   peak_col,
	output logic                            frame_done
);

	localparam int COL_AW = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS+1);
	localparam int JF_W   = $bits(gpd_pkg::job_t);
	localparam int JOB_W  = JF_W + COL_AW + SAMPLE_BITS;
	localparam int RES_W  = $bits(gpd_pkg::res_t);

	logic                  fe_push;
	gpd_pkg::job_t         fe_flags;
	logic [COL_AW-1:0]     fe_col;
	logic [JOB_W-1:0]      jq_wdata;
	logic [JOB_W-1:0]      jq_rdata;
	logic                  jq_empty;
	logic [$clog2(gpd_pkg::JOB_DEPTH+1)-1:0] jq_level;
	logic                  be_pop;
	gpd_pkg::job_t         be_flags;
	logic [COL_AW-1:0]     be_col;
	logic [SAMPLE_BITS-1:0] be_sample;
	logic                  be_push;
	gpd_pkg::res_t         be_res;
	logic [RES_W-1:0]      rq_rdata;
	gpd_pkg::res_t         rq_res;
	logic                  rq_full;
	logic [$clog2(gpd_pkg::RES_DEPTH+1)-1:0] rq_level;

	gpd_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.COL_AW   (COL_AW),
		.ROW_W    (ROW_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.op        (op),
		.job_full  (full),
		.job_push  (fe_push),
		.job_flags (fe_flags),
		.job_col   (fe_col)
	);

	assign jq_wdata = {fe_flags, fe_col, sample_value};

	gpd_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (gpd_pkg::JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (jq_wdata),
		.full   (full),
		.pop    (be_pop),
		.rdata  (jq_rdata),
		.empty  (jq_empty),
		.level  (jq_level)
	);

	assign be_flags  = gpd_pkg::job_t'(jq_rdata[JOB_W-1 -: JF_W]);
	assign be_col    = jq_rdata[COL_AW+SAMPLE_BITS-1 -: COL_AW];
	assign be_sample = jq_rdata[SAMPLE_BITS-1:0];

	gpd_back #(
		.MAX_COLS    (MAX_COLS),
		.COL_AW      (COL_AW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (jq_empty),
		.job_flags  (be_flags),
		.job_col    (be_col),
		.job_sample (be_sample),
		.job_pop    (be_pop),
		.res_level  (rq_level),
		.res_push   (be_push),
		.res_data   (be_res)
	);

	gpd_fifo #(
		.WIDTH (RES_W),
		.DEPTH (gpd_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (be_push),
		.wdata  (be_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty),
		.level  (rq_level)
	);

	assign rq_res     = gpd_pkg::res_t'(rq_rdata);
	assign peak_row   = rq_res.row;
	assign peak_col   = rq_res.col;
	assign frame_done = rq_res.done;

`ifndef SYNTHESIS
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		be_push |-> !rq_full)
		else $error("result transfer lost at the result queue");

	a_job_level: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (jq_level == ($bits(jq_level))'(gpd_pkg::JOB_DEPTH)))
		else $error("input stalled while the job queue has room");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		jq_empty |-> !be_pop)
		else $error("job taken from an empty job queue");
`endif

endmodule
